>>> design/swr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swr_pkg
// shared types, codes and field widths of the stack with roll unit
// ---------------------------------------------------------------------------
package swr_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int DATA_WIDTH_DEF  = 8;

    localparam int OP_W    = 2;
    localparam int VAL_W   = 8;
    localparam int NCNT_W  = 5;
    localparam int SHIFT_W = 8;
    localparam int ST_W    = 2;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    // operation codes, also used as command kinds toward the back end
    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_ROLL = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    kind;
        logic [VAL_W-1:0]   value;
        logic [NCNT_W-1:0]  n;
        logic [SHIFT_W-1:0] k;
    } t_cmd;

endpackage

>>> design/swr_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swr_front
// accepts transactions, classifies them and queues commands for the back end
// ---------------------------------------------------------------------------
module swr_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [swr_pkg::IN_TDATA_W-1:0]  i_in_tdata,
    input  logic [swr_pkg::OP_W-1:0]        i_in_tuser,
    output logic                            o_cmd_valid,
    output swr_pkg::t_cmd                   o_cmd,
    input  logic                            i_cmd_take
);
    import swr_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_cmd       dec;
    logic       acc;

    always_comb begin
        dec.value = i_in_tdata[7:0];
        dec.n     = i_in_tdata[12:8];
        dec.k     = i_in_tdata[20:13];
        // a roll of zero entries changes nothing
        if (i_in_tuser == OP_ROLL && dec.n == '0) begin
            dec.kind = OP_NOP;
        end else begin
            dec.kind = i_in_tuser;
        end
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign acc         = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q[r_wr] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (acc) begin
                r_wr <= ~r_wr;
            end
            if (i_cmd_take) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(acc) - 2'(i_cmd_take);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count overflow");
    a_take_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_take |-> r_cnt != 2'd0) else $error("take from empty queue");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && !i_cmd_take |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("queue count did not grow");

endmodule

>>> design/swr_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swr_back
// executes push, pop and roll on the stack memory and holds the result
// ---------------------------------------------------------------------------
module swr_back #(
    parameter int STACK_DEPTH = swr_pkg::STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = swr_pkg::DATA_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cmd_valid,
    input  swr_pkg::t_cmd                    i_cmd,
    output logic                             o_cmd_take,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [swr_pkg::OUT_TDATA_W-1:0]  o_out_tdata,
    output logic [swr_pkg::ST_W-1:0]         o_out_tuser
);
    import swr_pkg::*;

    localparam int ADDR_W    = $clog2(STACK_DEPTH);
    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int SUB_W     = (CNT_W > NCNT_W) ? CNT_W : NCNT_W;
    localparam int BUF_DEPTH = (STACK_DEPTH < 31) ? STACK_DEPTH : 31;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int PV_W      = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_POPD = 4'd2;
    localparam logic [3:0] S_MOD  = 4'd3;
    localparam logic [3:0] S_RDA  = 4'd4;
    localparam logic [3:0] S_RDD  = 4'd5;
    localparam logic [3:0] S_WRA  = 4'd6;
    localparam logic [3:0] S_WRD  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]            r_state;
    logic [CNT_W-1:0]      r_count;
    logic [OP_W-1:0]       r_kind;
    logic [VAL_W-1:0]      r_val;
    logic [NCNT_W-1:0]     r_n;
    logic [SHIFT_W-1:0]    r_k;
    logic [NCNT_W-1:0]     r_rem;
    logic [2:0]            r_bit;
    logic [NCNT_W-1:0]     r_i;
    logic [NCNT_W-1:0]     r_dst;
    logic [DATA_WIDTH-1:0] r_res_pop;
    logic [ST_W-1:0]       r_res_st;
    logic                  r_out_valid;
    logic [VAL_W-1:0]      r_out_pop;
    logic [ST_W-1:0]       r_out_st;
    logic [NCNT_W-1:0]     r_out_depth;

    logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];
    logic [DATA_WIDTH-1:0] r_mem_q;
    logic [DATA_WIDTH-1:0] rbuf [BUF_DEPTH];
    logic [DATA_WIDTH-1:0] r_buf_q;

    logic [SUB_W-1:0]      count_x;
    logic [SUB_W-1:0]      n_x;
    logic [SUB_W-1:0]      top_idx;
    logic [NCNT_W:0]       mod_t;
    logic [NCNT_W:0]       mod_s;
    logic [NCNT_W-1:0]     rem_next;
    logic [NCNT_W-1:0]     dst_inc;
    logic                  last_i;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_wa;
    logic [DATA_WIDTH-1:0] mem_wd;
    logic                  out_load;
    logic [PV_W-1:0]       push_x;
    logic [PV_W-1:0]       pop_x;

    assign count_x  = SUB_W'(r_count);
    assign n_x      = SUB_W'(r_n);
    assign top_idx  = count_x - SUB_W'(1) - SUB_W'(r_i);
    assign mod_t    = {r_rem, r_k[r_bit]};
    assign mod_s    = mod_t - {1'b0, r_n};
    assign rem_next = (mod_t >= {1'b0, r_n}) ? mod_s[NCNT_W-1:0] : mod_t[NCNT_W-1:0];
    assign dst_inc  = (r_dst + NCNT_W'(1) == r_n) ? '0 : r_dst + NCNT_W'(1);
    assign last_i   = (r_i == r_n - NCNT_W'(1));
    assign push_x   = PV_W'(r_val);
    assign pop_x    = PV_W'(r_res_pop);

    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = top_idx[ADDR_W-1:0];
        mem_wd = r_buf_q;
        if (r_state == S_EXEC && r_kind == OP_PUSH && r_count != CNT_W'(STACK_DEPTH)) begin
            mem_we = 1'b1;
            mem_wa = r_count[ADDR_W-1:0];
            mem_wd = push_x[DATA_WIDTH-1:0];
        end else if (r_state == S_WRD) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_mem_q <= mem[top_idx[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RDD) begin
            rbuf[r_dst[BUF_AW-1:0]] <= r_mem_q;
        end
        r_buf_q <= rbuf[r_i[BUF_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_kind)
                        OP_PUSH: begin
                            if (r_count == CNT_W'(STACK_DEPTH)) begin
                                r_res_st <= ST_FULL;
                            end else begin
                                r_count <= r_count + CNT_W'(1);
                            end
                            r_state <= S_DONE;
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                r_res_st <= ST_EMPTY;
                                r_state  <= S_DONE;
                            end else begin
                                r_count <= r_count - CNT_W'(1);
                                r_state <= S_POPD;
                            end
                        end
                        OP_ROLL: begin
                            if (n_x > count_x) begin
                                r_res_st <= ST_RANGE;
                                r_state  <= S_DONE;
                            end else begin
                                r_rem   <= '0;
                                r_bit   <= 3'd7;
                                r_state <= S_MOD;
                            end
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_POPD: begin
                    r_res_pop <= r_mem_q;
                    r_state   <= S_DONE;
                end
                S_MOD: begin
                    r_rem <= rem_next;
                    if (r_bit == 3'd0) begin
                        if (rem_next == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_dst   <= r_n - rem_next;
                            r_i     <= '0;
                            r_state <= S_RDA;
                        end
                    end else begin
                        r_bit <= r_bit - 3'd1;
                    end
                end
                S_RDA: begin
                    r_state <= S_RDD;
                end
                S_RDD: begin
                    r_dst <= dst_inc;
                    if (last_i) begin
                        r_i     <= '0;
                        r_state <= S_WRA;
                    end else begin
                        r_i     <= r_i + NCNT_W'(1);
                        r_state <= S_RDA;
                    end
                end
                S_WRA: begin
                    r_state <= S_WRD;
                end
                S_WRD: begin
                    if (last_i) begin
                        r_state <= S_DONE;
                    end else begin
                        r_i     <= r_i + NCNT_W'(1);
                        r_state <= S_WRA;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (o_cmd_take) begin
                r_kind    <= i_cmd.kind;
                r_val     <= i_cmd.value;
                r_n       <= i_cmd.n;
                r_k       <= i_cmd.k;
                r_i       <= '0;
                r_res_pop <= '0;
                r_res_st  <= ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pop   <= pop_x[VAL_W-1:0];
            r_out_st    <= r_res_st;
            r_out_depth <= count_x[NCNT_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_tdata = {3'b000, r_out_depth, r_out_pop};
    assign o_out_tuser = r_out_st;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH)) else $error("stack count above depth");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MOD |-> r_rem < r_n) else $error("remainder not below n");
    a_roll_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDD || r_state == S_WRD) |-> (r_i < r_n && r_dst < r_n))
        else $error("roll index out of range");
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid && r_state == S_IDLE)
        else $error("result not presented");

endmodule

>>> design/stack_with_roll_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stack_with_roll_unit
// bounded stack with push, pop and roll for a stack-machine interpreter
// ---------------------------------------------------------------------------
// each input transaction is one push, pop, roll(n, k) or no-op and yields exactly one
// output transaction carrying the popped entry, a status and the new depth.
// the front end queues up to two decoded commands so the input keeps flowing
// while the back end works; the back end runs one command at a time on a
// one-write, one-read stack memory with registered read data. a roll first
// reduces k modulo n with a bit-serial remainder, then reads the rolled entries
// into a rotation buffer and writes them back rotated. a roll with n above
// the current depth returns status range, n of zero or k a multiple of n leaves
// the stack as it is, pop on empty and push on full return their own status.
// the result sits in an output register until taken.
module stack_with_roll_unit #(
    parameter int STACK_DEPTH = swr_pkg::STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = swr_pkg::DATA_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // push_value [7:0], roll_count [12:8], roll_shift [20:13], zero fill
    input  logic [swr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // opcode [1:0]
    input  logic [swr_pkg::OP_W-1:0]         s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // pop_value [7:0], depth_now [12:8], zero fill
    output logic [swr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // status [1:0]
    output logic [swr_pkg::ST_W-1:0]         m_axis_tuser
);
    import swr_pkg::*;

    // decoded command queue between front and back
    logic cmd_valid;
    t_cmd cmd;
    logic cmd_take;

    swr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_tdata  (s_axis_tdata),
        .i_in_tuser  (s_axis_tuser),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    // stack memory, roll sequencer and result register
    swr_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_tdata (m_axis_tdata),
        .o_out_tuser (m_axis_tuser)
    );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the stack with roll unit
// ---------------------------------------------------------------------------
// drives push, pop, roll and no-op transactions with random gaps and output stalls,
// keeps a shadow stack to predict each result, and compares every output
// transaction field by field against the oldest prediction
module testbench;
    import swr_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0]  pop_value;
        logic [ST_W-1:0]   status;
        logic [NCNT_W-1:0] depth_now;
    } t_stack_result;

    logic i_clk;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    logic [OP_W-1:0] s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [ST_W-1:0] m_axis_tuser;

    // shadow stack, entry 0 is the bottom
    logic [VAL_W-1:0] shadow_stack [STACK_DEPTH_DEF];
    int shadow_depth;
    t_stack_result result_queue [$];
    int error_count;
    int idle_cycles;
    bit gaps_on;

    stack_with_roll_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // work out the result of one operation and update the shadow stack
    function automatic t_stack_result predict_stack_op(logic [OP_W-1:0] op,
            logic [VAL_W-1:0] val, logic [NCNT_W-1:0] n, logic [SHIFT_W-1:0] k);
        t_stack_result r;
        logic [VAL_W-1:0] rotated [STACK_DEPTH_DEF];
        int kk;
        int top;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH: begin
                if (shadow_depth >= STACK_DEPTH_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_stack[shadow_depth] = val;
                    shadow_depth++;
                end
            end
            OP_POP: begin
                if (shadow_depth == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    shadow_depth--;
                    r.pop_value = shadow_stack[shadow_depth];
                end
            end
            OP_ROLL: begin
                if (n > shadow_depth) begin
                    r.status = ST_RANGE;
                end else if (n != 0) begin
                    kk = k % n;
                    top = shadow_depth - 1;
                    // depth i moves to depth (i - k) mod n
                    for (int i = 0; i < n; i++)
                        rotated[(i + n - kk) % n] = shadow_stack[top - i];
                    for (int i = 0; i < n; i++)
                        shadow_stack[top - i] = rotated[i];
                end
            end
            default: ;
        endcase
        r.depth_now = NCNT_W'(shadow_depth);
        return r;
    endfunction

    // send one transaction, predicting its result when it is accepted
    task automatic send_op(logic [OP_W-1:0] op, logic [VAL_W-1:0] val,
            logic [NCNT_W-1:0] n, logic [SHIFT_W-1:0] k);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {3'b0, k, n, val};
        do @(posedge i_clk); while (!s_axis_tready);
        result_queue.push_back(predict_stack_op(op, val, n, k));
    endtask

    task automatic random_op(int push_weight, int pop_weight);
        int sel;
        logic [NCNT_W-1:0] n;
        sel = $urandom_range(0, push_weight + pop_weight + 9);
        // mostly in-range roll counts, some beyond depth or above 16
        if ($urandom_range(0, 7) == 0) n = NCNT_W'($urandom_range(0, 31));
        else n = NCNT_W'($urandom_range(0, shadow_depth));
        if (sel < push_weight)
            send_op(OP_PUSH, VAL_W'($urandom_range(0, 255)),
                    NCNT_W'($urandom_range(0, 31)), SHIFT_W'($urandom_range(0, 255)));
        else if (sel < push_weight + pop_weight)
            send_op(OP_POP, VAL_W'($urandom_range(0, 255)),
                    NCNT_W'($urandom_range(0, 31)), SHIFT_W'($urandom_range(0, 255)));
        else if (sel == push_weight + pop_weight)
            send_op(OP_NOP, VAL_W'($urandom_range(0, 255)), n,
                    SHIFT_W'($urandom_range(0, 255)));
        else
            send_op(OP_ROLL, VAL_W'($urandom_range(0, 255)), n,
                    SHIFT_W'($urandom_range(0, 255)));
    endtask

    task automatic test_directed;
        send_op(OP_POP, 8'h00, 5'd0, 8'h00);     // pop on empty
        send_op(OP_ROLL, 8'h00, 5'd1, 8'h01);    // roll beyond depth
        send_op(OP_ROLL, 8'h00, 5'd0, 8'hff);    // roll count zero
        send_op(OP_NOP, 8'hff, 5'd31, 8'hff);    // unused opcode
        for (int i = 0; i < STACK_DEPTH_DEF; i++)
            send_op(OP_PUSH, (i == 0) ? 8'hff : 8'(i * 17), 5'd0, 8'h00);
        send_op(OP_PUSH, 8'haa, 5'd31, 8'hff);   // push on full
        send_op(OP_ROLL, 8'h00, 5'd16, 8'd255);  // full-depth roll, max shift
        send_op(OP_ROLL, 8'h00, 5'd4, 8'd8);     // shift a multiple of n
        send_op(OP_ROLL, 8'h00, 5'd17, 8'd3);    // count above max depth
        send_op(OP_POP, 8'h00, 5'd0, 8'h00);
    endtask

    task automatic test_random_mixed;
        for (int i = 0; i < 1400; i++) begin
            // drift between filling and draining phases
            if ((i / 100) % 2 == 0) random_op(12, 6);
            else random_op(6, 12);
        end
    endtask

    task automatic test_no_idling;
        gaps_on = 1'b0;
        for (int i = 0; i < 450; i++) random_op(9, 9);
    endtask

    // output side: random stalls and result checking
    always @(posedge i_clk) begin
        t_stack_result exp_r;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (result_queue.size() == 0) begin
                    $display("%0t: unexpected result tdata=%h tuser=%h", $time,
                             m_axis_tdata, m_axis_tuser);
                    error_count++;
                end else begin
                    exp_r = result_queue.pop_front();
                    if (m_axis_tdata[7:0] !== exp_r.pop_value) begin
                        $display("%0t: pop_value expected %h actual %h", $time,
                                 exp_r.pop_value, m_axis_tdata[7:0]);
                        error_count++;
                    end
                    if (m_axis_tuser !== exp_r.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_r.status, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tdata[12:8] !== exp_r.depth_now) begin
                        $display("%0t: depth_now expected %0d actual %0d", $time,
                                 exp_r.depth_now, m_axis_tdata[12:8]);
                        error_count++;
                    end
                end
            end
            if (gaps_on && idle_cycles == 0 && $urandom_range(0, 5) == 0) begin
                idle_cycles <= $urandom_range(1, 8);
                m_axis_tready <= 1'b0;
            end else if (idle_cycles > 0) begin
                idle_cycles <= idle_cycles - 1;
                m_axis_tready <= (idle_cycles == 1);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no accepted transaction
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= 2000) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    initial begin
        error_count = 0;
        idle_cycles = 0;
        gaps_on = 1'b1;
        shadow_depth = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_NOP;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_mixed();
        test_no_idling();
        s_axis_tvalid <= 1'b0;
        while (result_queue.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && result_queue.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
